// ===== rtl/core/ipoc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipoc_pkg: shared types and constants
// Widths, limits, status codes and the multiplier request/response beats.
// ----------------------------------------------------------------------------
package ipoc_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int HALF_W     = DATA_WIDTH / 2;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int EXP_W      = 32;

    localparam logic [DATA_WIDTH-1:0] LIMIT =
        DATA_WIDTH'((65'd1 << (DATA_WIDTH - 1)) - 65'd1);
    localparam logic [DATA_WIDTH-1:0] SQUARE_CAP = DATA_WIDTH'(100000000);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_DOMAIN   = 2'd2;

    typedef struct packed {
        logic                  start;
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } mul_rsp_t;

endpackage : ipoc_pkg
`default_nettype wire

// ===== rtl/core/integer_power_overflow_check_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// integer_power_overflow_check_top: signed integer power with overflow check
// Square-and-multiply over the exponent magnitude on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   A beat (base, exponent) is taken at a clock edge where start is high and
//   busy is low. Each beat gives one result beat: value, status, reciprocal
//   and negative are valid for the single cycle in which done is high.
//   Zero, unit and minus-unit exponents and bases of 0, 1 and -1 give their
//   result in the cycle after acceptance, with busy staying low.
//   Other beats run the square-and-multiply loop: each multiply goes through
//   the four-partial-product multiplier, each exponent bit at most two
//   multiplies plus a check state. The overflow bound allows at most five
//   squarings, so the loop runs at most six steps; done follows in the cycle
//   after busy falls, and the next beat can be taken at the edge that ends
//   the done cycle. busy is high throughout the loop. done has no
//   back-pressure: the receiver must take each result beat when it appears.
//   Reset clears the sequencer and drops done and busy.
// ----------------------------------------------------------------------------
module integer_power_overflow_check_top
    import ipoc_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [DATA_WIDTH-1:0] base,
    input  wire logic signed [EXP_W-1:0]      exponent,
    output logic                              done,
    output logic signed [DATA_WIDTH-1:0]      value,
    output logic        [1:0]                 status,
    output logic                              reciprocal,
    output logic                              negative
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_MUL_ACC = 3'd2;
    localparam logic [2:0] S_MUL_SQ  = 3'd3;
    localparam logic [2:0] S_FIN     = 3'd4;

    logic [2:0]            state_reg,  state_next;
    logic [EXP_W-1:0]      k_reg,      k_next;
    logic [DATA_WIDTH-1:0] p_reg,      p_next;
    logic [DATA_WIDTH-1:0] acc_reg,    acc_next;
    logic                  inv_reg,    inv_next;
    logic                  negz_reg,   negz_next;
    logic                  done_reg,   done_next;
    logic [DATA_WIDTH-1:0] value_reg,  value_next;
    logic [1:0]            status_reg, status_next;
    logic                  recip_reg,  recip_next;
    logic                  neg_reg,    neg_next;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    logic [DATA_WIDTH-1:0] base_u;
    logic [EXP_W-1:0]      exp_u;
    logic                  inv_in;
    logic [EXP_W-1:0]      mag_in;
    logic                  bneg_in;
    logic                  base_zero;
    logic                  base_one;
    logic                  base_mone;
    logic                  prod_over;
    logic                  p_capped;
    logic [DATA_WIDTH-1:0] acc_new;

    assign base_u    = DATA_WIDTH'(base);
    assign exp_u     = EXP_W'(exponent);
    assign inv_in    = exp_u[EXP_W-1];
    assign mag_in    = inv_in ? (EXP_W'(0) - exp_u) : exp_u;
    assign bneg_in   = base_u[DATA_WIDTH-1];
    assign base_zero = (base_u == '0);
    assign base_one  = (base_u == DATA_WIDTH'(1));
    assign base_mone = (base_u == '1);
    assign prod_over = (mul_rsp.prod > {{DATA_WIDTH{1'b0}}, LIMIT});
    assign p_capped  = (p_reg >= SQUARE_CAP);
    assign acc_new   = mul_rsp.prod[DATA_WIDTH-1:0] - p_reg;

    ipoc_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        p_next      = p_reg;
        acc_next    = acc_reg;
        inv_next    = inv_reg;
        negz_next   = negz_reg;
        done_next   = 1'b0;
        value_next  = value_reg;
        status_next = status_reg;
        recip_next  = recip_reg;
        neg_next    = neg_reg;
        mul_req.start = 1'b0;
        mul_req.a     = acc_reg + DATA_WIDTH'(1);
        mul_req.b     = p_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (mag_in == '0)
                    begin
                        done_next   = 1'b1;
                        value_next  = DATA_WIDTH'(1);
                        status_next = ST_OK;
                        recip_next  = 1'b0;
                        neg_next    = 1'b0;
                    end
                    else if (mag_in == EXP_W'(1))
                    begin
                        done_next = 1'b1;
                        if (inv_in && base_zero)
                        begin
                            value_next  = '0;
                            status_next = ST_DOMAIN;
                            recip_next  = 1'b0;
                            neg_next    = 1'b0;
                        end
                        else
                        begin
                            value_next  = base_u;
                            status_next = ST_OK;
                            recip_next  = inv_in && !base_one && !base_mone;
                            neg_next    = bneg_in;
                        end
                    end
                    else if (base_zero)
                    begin
                        done_next   = 1'b1;
                        value_next  = '0;
                        status_next = inv_in ? ST_DOMAIN : ST_OK;
                        recip_next  = 1'b0;
                        neg_next    = 1'b0;
                    end
                    else if (base_one || base_mone)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        recip_next  = 1'b0;
                        neg_next    = base_mone && mag_in[0];
                        value_next  = (base_mone && mag_in[0]) ? '1 : DATA_WIDTH'(1);
                    end
                    else
                    begin
                        p_next     = bneg_in ? (DATA_WIDTH'(0) - base_u) : base_u;
                        acc_next   = DATA_WIDTH'(1);
                        k_next     = mag_in;
                        inv_next   = inv_in;
                        negz_next  = bneg_in && mag_in[0];
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (k_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else if (k_reg[0])
                begin
                    mul_req.start = 1'b1;
                    state_next    = S_MUL_ACC;
                end
                else if (p_capped)
                begin
                    done_next   = 1'b1;
                    value_next  = '0;
                    status_next = ST_OVERFLOW;
                    recip_next  = inv_reg;
                    neg_next    = negz_reg;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = p_reg;
                    state_next    = S_MUL_SQ;
                end
            end
            S_MUL_ACC:
            begin
                if (mul_rsp.done)
                begin
                    // (acc+1)*p > LIMIT is the same test as acc >= LIMIT/p
                    if (prod_over || (k_reg != EXP_W'(1) && p_capped))
                    begin
                        done_next   = 1'b1;
                        value_next  = '0;
                        status_next = ST_OVERFLOW;
                        recip_next  = inv_reg;
                        neg_next    = negz_reg;
                        state_next  = S_IDLE;
                    end
                    else if (k_reg == EXP_W'(1))
                    begin
                        acc_next   = acc_new;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        acc_next      = acc_new;
                        mul_req.start = 1'b1;
                        mul_req.a     = p_reg;
                        state_next    = S_MUL_SQ;
                    end
                end
            end
            S_MUL_SQ:
            begin
                if (mul_rsp.done)
                begin
                    p_next     = mul_rsp.prod[DATA_WIDTH-1:0];
                    k_next     = k_reg >> 1;
                    state_next = S_CHECK;
                end
            end
            S_FIN:
            begin
                done_next   = 1'b1;
                value_next  = negz_reg ? (DATA_WIDTH'(0) - acc_reg) : acc_reg;
                status_next = ST_OK;
                recip_next  = inv_reg;
                neg_next    = negz_reg;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        p_reg      <= p_next;
        acc_reg    <= acc_next;
        inv_reg    <= inv_next;
        negz_reg   <= negz_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        recip_reg  <= recip_next;
        neg_reg    <= neg_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign value      = value_reg;
    assign status     = status_reg;
    assign reciprocal = recip_reg;
    assign negative   = neg_reg;

`ifndef NO_ASSERTIONS
    a_mul_start_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |=> (state_reg == S_MUL_ACC || state_reg == S_MUL_SQ))
        else $error("multiplier started outside a multiply state");

    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == S_MUL_ACC || state_reg == S_MUL_SQ))
        else $error("multiplier beat with no multiply pending");

    a_ovf_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_OVERFLOW) |-> (value == '0))
        else $error("overflow result carries a value");

    a_domain_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_DOMAIN) |-> (value == '0 && !reciprocal && !negative))
        else $error("domain error result carries marks");
`endif

endmodule : integer_power_overflow_check_top
`default_nettype wire

// ===== rtl/core/ipoc_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipoc_mul: iterative unsigned multiplier
// Full-width product from four half-width partial products, one per cycle,
// each registered before it is shifted into the running sum.
// ----------------------------------------------------------------------------
module ipoc_mul
    import ipoc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    localparam logic [2:0] LAST_CNT = 3'd4;
    localparam logic [1:0] SH_ZERO  = 2'd0;
    localparam logic [1:0] SH_ONE   = 2'd1;

    logic                  run_reg;
    logic                  done_reg;
    logic [2:0]            cnt_reg;
    logic [DATA_WIDTH-1:0] a_reg;
    logic [DATA_WIDTH-1:0] b_reg;
    logic [DATA_WIDTH-1:0] pp_reg;
    logic [1:0]            sh_reg;
    logic [PROD_W-1:0]     sum_reg;

    logic [HALF_W-1:0]     a_half;
    logic [HALF_W-1:0]     b_half;
    logic [PROD_W-1:0]     pp_shifted;

    assign a_half = cnt_reg[1] ? a_reg[DATA_WIDTH-1:HALF_W] : a_reg[HALF_W-1:0];
    assign b_half = cnt_reg[0] ? b_reg[DATA_WIDTH-1:HALF_W] : b_reg[HALF_W-1:0];

    always_comb
    begin
        case (sh_reg)
            SH_ZERO:
            begin
                pp_shifted = {{DATA_WIDTH{1'b0}}, pp_reg};
            end
            SH_ONE:
            begin
                pp_shifted = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
            end
            default:
            begin
                pp_shifted = {pp_reg, {DATA_WIDTH{1'b0}}};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == LAST_CNT)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            sum_reg <= '0;
        end
        else if (run_reg)
        begin
            pp_reg <= DATA_WIDTH'(a_half) * DATA_WIDTH'(b_half);
            sh_reg <= 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
            if (cnt_reg != 3'd0)
            begin
                sum_reg <= sum_reg + pp_shifted;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = sum_reg;

endmodule : ipoc_mul
`default_nettype wire
